FILE: design/rrpq_pkg.sv
// ----------------------------------------------------------------------------
// rrpq_pkg
// Types and codes shared by the route request packet queue modules.
// ----------------------------------------------------------------------------
package rrpq_pkg;

    localparam int unsigned REQ_W   = 3;
    localparam int unsigned ID_W    = 32;
    localparam int unsigned OUT_W   = 32;
    localparam int unsigned CNT_W   = 6;
    localparam int unsigned LIFE_W  = 17;
    localparam int unsigned TOUT_W  = 16;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [2:0] REQ_TICK  = 3'd0;
    localparam logic [2:0] REQ_ENQ   = 3'd1;
    localparam logic [2:0] REQ_DEQ   = 3'd2;
    localparam logic [2:0] REQ_DROP  = 3'd3;
    localparam logic [2:0] REQ_FIND  = 3'd4;
    localparam logic [2:0] REQ_SIZE  = 3'd5;

    localparam logic [1:0] CAUSE_EXPIRED = 2'd0;
    localparam logic [1:0] CAUSE_EVICTED = 2'd1;
    localparam logic [1:0] CAUSE_BY_DEST = 2'd2;

    localparam logic CFG_MAX_LENGTH    = 1'b0;
    localparam logic CFG_ENTRY_TIMEOUT = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PURGE_RD,
        ST_PURGE,
        ST_OP_RD,
        ST_OP,
        ST_EVICT_RD,
        ST_EVICT,
        ST_APPEND,
        ST_REPLY
    } t_state;

    // scan modes of the datapath
    typedef enum logic [2:0] {
        SCAN_EXPIRE,
        SCAN_TICK,
        SCAN_DUP,
        SCAN_DEQ,
        SCAN_DROP,
        SCAN_FIND,
        SCAN_EVICT
    } t_scan;

    typedef struct packed {
        logic       load;       // capture request
        logic       scan_start; // reset scan indexes
        logic       scan_step;  // process one slot
        t_scan      mode;
        logic       scan_end;   // commit compacted count
        logic       append;     // write new entry
        logic       reply;      // final reply
    } t_cmd;

    typedef struct packed {
        logic       scan_done;  // read index reached count
        logic       dup_found;
        logic       need_evict;
        logic [REQ_W-1:0] req;
    } t_status;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic [ID_W-1:0]  packet_id;
        logic [ID_W-1:0]  dest_addr;
    } t_req;

    typedef struct packed {
        logic             is_drop;
        logic [1:0]       drop_cause;
        logic             success;
        logic [OUT_W-1:0] out_packet_id;
        logic [OUT_W-1:0] out_dest;
        logic [CNT_W-1:0] entry_count;
        logic             last;
    } t_result;

endpackage

FILE: design/route_request_packet_queue.sv
// ----------------------------------------------------------------------------
// route_request_packet_queue
// Age-ordered buffer of packet handles with lifetimes, purge and eviction.
// ----------------------------------------------------------------------------
// channel  | ports                          | handshake
// request  | i_start, i_req                 | taken when i_start && !o_busy
// result   | o_valid, o_result              | one cycle per word, no stall
// config   | i_cfg_we, i_cfg_idx, i_cfg_data| written when i_cfg_we
// Tick, enqueue, dequeue, drop and size first purge expired slots; find does
// not. Size and unknown requests then reply; the others scan the slots, and an
// enqueue that is no duplicate evicts when full, then appends. Scans run one
// slot per cycle; each word is registered before it leaves, the final word in
// the idle cycle. Reset is synchronous, active low, and empties the queue.
// Results cannot be stalled.
// ----------------------------------------------------------------------------
module route_request_packet_queue #(
    parameter int unsigned QUEUE_DEPTH = 32,
    parameter int unsigned ADDR_WIDTH  = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  rrpq_pkg::t_req                 i_req,
    output logic                           o_busy,
    output logic                           o_valid,
    output rrpq_pkg::t_result              o_result,
    input  logic                           i_cfg_we,
    input  logic [rrpq_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rrpq_pkg::TOUT_W-1:0]    i_cfg_data
);

    logic [rrpq_pkg::CNT_W-1:0]  r_max_length;
    logic [rrpq_pkg::TOUT_W-1:0] r_entry_timeout;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length    <= rrpq_pkg::CNT_W'(32);
            r_entry_timeout <= rrpq_pkg::TOUT_W'(30);
        end else if (i_cfg_we) begin
            if (i_cfg_idx == rrpq_pkg::CFG_MAX_LENGTH)
                r_max_length <= i_cfg_data[rrpq_pkg::CNT_W-1:0];
            else
                r_entry_timeout <= i_cfg_data;
        end
    end

    rrpq_pkg::t_cmd    cmd;
    rrpq_pkg::t_status status;

    rrpq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_status (status),
        .o_busy   (o_busy),
        .o_cmd    (cmd)
    );

    rrpq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ADDR_WIDTH  (ADDR_WIDTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req           (i_req),
        .i_max_length    (r_max_length),
        .i_entry_timeout (r_entry_timeout),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_valid         (o_valid),
        .o_result        (o_result)
    );

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy);
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.last) |=> !o_valid);
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_busy || o_result.last));
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.is_drop) |-> !o_result.last);

endmodule

FILE: design/rrpq_ctrl.sv
// ----------------------------------------------------------------------------
// rrpq_ctrl
// Sequencer: purge scan, operation scan, eviction scan, append and final reply.
// ----------------------------------------------------------------------------
module rrpq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  rrpq_pkg::t_status  i_status,
    output logic               o_busy,
    output rrpq_pkg::t_cmd     o_cmd
);

    rrpq_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rrpq_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    logic purge_req;
    assign purge_req = (i_status.req <= rrpq_pkg::REQ_SIZE)
                       && (i_status.req != rrpq_pkg::REQ_FIND);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rrpq_pkg::ST_IDLE: begin
                if (i_start) n_state = rrpq_pkg::ST_PURGE_RD;
            end
            rrpq_pkg::ST_PURGE_RD: begin
                n_state = purge_req ? rrpq_pkg::ST_PURGE : rrpq_pkg::ST_OP_RD;
            end
            rrpq_pkg::ST_PURGE: begin
                if (i_status.scan_done) n_state = rrpq_pkg::ST_OP_RD;
            end
            rrpq_pkg::ST_OP_RD: begin
                if (i_status.req == rrpq_pkg::REQ_SIZE || i_status.req > rrpq_pkg::REQ_SIZE)
                    n_state = rrpq_pkg::ST_REPLY;
                else
                    n_state = rrpq_pkg::ST_OP;
            end
            rrpq_pkg::ST_OP: begin
                if (i_status.scan_done) begin
                    if (i_status.req == rrpq_pkg::REQ_ENQ && !i_status.dup_found)
                        n_state = i_status.need_evict ? rrpq_pkg::ST_EVICT_RD
                                                      : rrpq_pkg::ST_APPEND;
                    else
                        n_state = rrpq_pkg::ST_REPLY;
                end
            end
            rrpq_pkg::ST_EVICT_RD: n_state = rrpq_pkg::ST_EVICT;
            rrpq_pkg::ST_EVICT: begin
                if (i_status.scan_done) n_state = rrpq_pkg::ST_APPEND;
            end
            rrpq_pkg::ST_APPEND: n_state = rrpq_pkg::ST_REPLY;
            rrpq_pkg::ST_REPLY:  n_state = rrpq_pkg::ST_IDLE;
            default:             n_state = rrpq_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.mode = rrpq_pkg::SCAN_EXPIRE;
        o_busy = (r_state != rrpq_pkg::ST_IDLE);
        unique case (r_state)
            rrpq_pkg::ST_IDLE: begin
                o_cmd.load = i_start;
            end
            rrpq_pkg::ST_PURGE_RD: begin
                o_cmd.scan_start = 1'b1;
            end
            rrpq_pkg::ST_PURGE: begin
                o_cmd.mode      = rrpq_pkg::SCAN_EXPIRE;
                o_cmd.scan_step = !i_status.scan_done;
                o_cmd.scan_end  = i_status.scan_done;
            end
            rrpq_pkg::ST_OP_RD: begin
                o_cmd.scan_start = 1'b1;
            end
            rrpq_pkg::ST_OP: begin
                case (i_status.req)
                    rrpq_pkg::REQ_TICK: o_cmd.mode = rrpq_pkg::SCAN_TICK;
                    rrpq_pkg::REQ_ENQ:  o_cmd.mode = rrpq_pkg::SCAN_DUP;
                    rrpq_pkg::REQ_DEQ:  o_cmd.mode = rrpq_pkg::SCAN_DEQ;
                    rrpq_pkg::REQ_DROP: o_cmd.mode = rrpq_pkg::SCAN_DROP;
                    default:            o_cmd.mode = rrpq_pkg::SCAN_FIND;
                endcase
                o_cmd.scan_step = !i_status.scan_done;
                o_cmd.scan_end  = i_status.scan_done;
            end
            rrpq_pkg::ST_EVICT_RD: begin
                o_cmd.scan_start = 1'b1;
            end
            rrpq_pkg::ST_EVICT: begin
                o_cmd.mode      = rrpq_pkg::SCAN_EVICT;
                o_cmd.scan_step = !i_status.scan_done;
                o_cmd.scan_end  = i_status.scan_done;
            end
            rrpq_pkg::ST_APPEND: begin
                o_cmd.append = 1'b1;
            end
            rrpq_pkg::ST_REPLY: begin
                o_cmd.reply = 1'b1;
            end
            default: ;
        endcase
    end

endmodule

FILE: design/rrpq_dp.sv
// ----------------------------------------------------------------------------
// rrpq_dp
// Slot memory with a read pointer and a write pointer for in-place compaction.
// ----------------------------------------------------------------------------
module rrpq_dp #(
    parameter int unsigned QUEUE_DEPTH = 32,
    parameter int unsigned ADDR_WIDTH  = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rrpq_pkg::t_req                i_req,
    input  logic [rrpq_pkg::CNT_W-1:0]    i_max_length,
    input  logic [rrpq_pkg::TOUT_W-1:0]   i_entry_timeout,
    input  rrpq_pkg::t_cmd                i_cmd,
    output rrpq_pkg::t_status             o_status,
    output logic                          o_valid,
    output rrpq_pkg::t_result             o_result
);

    localparam int unsigned IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned HC_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned ENT_W = rrpq_pkg::ID_W + ADDR_WIDTH + rrpq_pkg::LIFE_W;

    logic [ENT_W-1:0] r_mem [QUEUE_DEPTH];

    logic [rrpq_pkg::REQ_W-1:0] r_req;
    logic [rrpq_pkg::ID_W-1:0]  r_id;
    logic [ADDR_WIDTH-1:0]      r_dst;
    logic [HC_W-1:0]            r_count;
    logic [HC_W-1:0]            r_rd;
    logic [HC_W-1:0]            r_wr;
    logic                       r_hit;
    logic                       r_removed;
    logic [ENT_W-1:0]           r_rdata;
    logic                       r_valid;
    rrpq_pkg::t_result          r_result;

    logic [rrpq_pkg::ID_W-1:0]  e_id;
    logic [ADDR_WIDTH-1:0]      e_dst;
    logic [rrpq_pkg::LIFE_W-1:0] e_life;
    assign {e_id, e_dst, e_life} = r_rdata;

    logic [HC_W-1:0] cap;
    always_comb begin
        if (i_max_length == '0)
            cap = HC_W'(1);
        else if ({{(32 - rrpq_pkg::CNT_W){1'b0}}, i_max_length} > 32'(QUEUE_DEPTH))
            cap = HC_W'(QUEUE_DEPTH);
        else
            cap = HC_W'(i_max_length);
    end

    logic expired, dmatch, evict_hit, drop_now, keep;
    assign expired   = e_life[rrpq_pkg::LIFE_W-1];
    assign dmatch    = (e_dst == r_dst);
    assign evict_hit = ({1'b0, r_rd} + {1'b0, cap}) <= {1'b0, r_count};
    assign o_status.scan_done  = (r_rd >= r_count);
    assign o_status.dup_found  = r_hit;
    assign o_status.need_evict = (r_count >= cap) && (r_count != '0);
    assign o_status.req        = r_req;

    always_comb begin
        drop_now = 1'b0;
        case (i_cmd.mode)
            rrpq_pkg::SCAN_EXPIRE: drop_now = expired;
            rrpq_pkg::SCAN_DROP:   drop_now = dmatch;
            rrpq_pkg::SCAN_DEQ:    drop_now = dmatch && !r_removed;
            rrpq_pkg::SCAN_EVICT:  drop_now = evict_hit;
            default:               drop_now = 1'b0;
        endcase
        keep = !drop_now;
    end

    logic [rrpq_pkg::LIFE_W-1:0] n_life;
    assign n_life = (i_cmd.mode == rrpq_pkg::SCAN_TICK && !expired)
                    ? e_life - rrpq_pkg::LIFE_W'(1) : e_life;

    // read address: slot after the current step, or slot 0 at scan start
    logic [HC_W-1:0] rd_next;
    always_comb begin
        rd_next = r_rd;
        if (i_cmd.scan_start)     rd_next = '0;
        else if (i_cmd.scan_step) rd_next = r_rd + HC_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_step && keep)
            r_mem[r_wr[IDX_W-1:0]] <= {e_id, e_dst, n_life};
        else if (i_cmd.append)
            r_mem[r_count[IDX_W-1:0]] <= {r_id, r_dst,
                {1'b0, i_entry_timeout}};
        if (rd_next < HC_W'(QUEUE_DEPTH))
            r_rdata <= r_mem[rd_next[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req.req_type;
            r_id  <= i_req.packet_id;
            r_dst <= ADDR_WIDTH'(i_req.dest_addr);
        end
    end

    rrpq_pkg::t_result n_result;
    logic              n_valid;
    always_comb begin
        n_result = '0;
        n_valid  = 1'b0;
        if (i_cmd.scan_step && drop_now && i_cmd.mode != rrpq_pkg::SCAN_DEQ) begin
            n_valid = 1'b1;
            n_result.is_drop = 1'b1;
            case (i_cmd.mode)
                rrpq_pkg::SCAN_DROP:  n_result.drop_cause = rrpq_pkg::CAUSE_BY_DEST;
                rrpq_pkg::SCAN_EVICT: n_result.drop_cause = rrpq_pkg::CAUSE_EVICTED;
                default:              n_result.drop_cause = rrpq_pkg::CAUSE_EXPIRED;
            endcase
            n_result.out_packet_id = e_id;
            n_result.out_dest = rrpq_pkg::OUT_W'(e_dst);
        end else if (i_cmd.reply) begin
            n_valid = 1'b1;
            n_result = r_result;
            n_result.success = (r_req == rrpq_pkg::REQ_ENQ) ? !r_hit
                             : (r_req == rrpq_pkg::REQ_DEQ || r_req == rrpq_pkg::REQ_FIND)
                               ? r_hit : 1'b0;
            n_result.entry_count = rrpq_pkg::CNT_W'(r_count);
            n_result.last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
            if (i_cmd.scan_end && i_cmd.mode != rrpq_pkg::SCAN_TICK
                && i_cmd.mode != rrpq_pkg::SCAN_FIND && i_cmd.mode != rrpq_pkg::SCAN_DUP)
                r_count <= r_wr;
            else if (i_cmd.append)
                r_count <= r_count + HC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        o_result <= n_valid ? n_result : '0;
        r_rd <= rd_next;
        if (i_cmd.scan_start) begin
            r_wr      <= '0;
            r_removed <= 1'b0;
            r_hit     <= 1'b0;
            r_result  <= '0;
        end else if (i_cmd.scan_step) begin
            if (keep) r_wr <= r_wr + HC_W'(1);
            case (i_cmd.mode)
                rrpq_pkg::SCAN_DUP:
                    if (dmatch && e_id == r_id) r_hit <= 1'b1;
                rrpq_pkg::SCAN_FIND:
                    if (dmatch) r_hit <= 1'b1;
                rrpq_pkg::SCAN_DEQ:
                    if (dmatch && !r_removed) begin
                        r_hit <= 1'b1;
                        r_removed <= 1'b1;
                        r_result.out_packet_id <= e_id;
                        r_result.out_dest <= rrpq_pkg::OUT_W'(e_dst);
                    end
                default: ;
            endcase
        end
    end

    assign o_valid = r_valid;

endmodule

FILE: test/tb_route_request_packet_queue.sv
// ----------------------------------------------------------------------------
// tb_route_request_packet_queue
// Drives tick, enqueue, dequeue, drop, find, size and unknown requests into
// the packet queue under several length and timeout settings and idle patterns, and
// checks every result word against a cycle-free model of the aged buffer.
// ----------------------------------------------------------------------------
module tb_route_request_packet_queue;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH   = 32;
    localparam int WDOG    = 20000;
    localparam logic [2:0] REQ_BAD6 = 3'd6;
    localparam logic [2:0] REQ_BAD7 = 3'd7;

    class queue_scoreboard;
        logic [31:0] ids[$];
        logic [31:0] dsts[$];
        logic [16:0] lives[$];
        int unsigned max_len = 32;
        logic [15:0] timeout = 16'd30;
        rrpq_pkg::t_result pending[$];
        int          errors = 0;
        int          words = 0;

        function void put_word(logic d, logic [1:0] c, logic ok, logic [31:0] id,
                               logic [31:0] dst, logic [5:0] cnt, logic lst);
            rrpq_pkg::t_result r;
            r.is_drop = d; r.drop_cause = c; r.success = ok; r.out_packet_id = id;
            r.out_dest = dst; r.entry_count = cnt; r.last = lst;
            pending.insert(pending.size(), r);
        endfunction

        function void sweep(logic by_dest, logic [31:0] dst, logic [1:0] cause);
            int i;
            logic hit;
            i = 0;
            while (i < ids.size()) begin
                hit = by_dest ? (dsts[i] == dst) : lives[i][16];
                if (hit) begin
                    put_word(1'b1, cause, 1'b0, ids[i], dsts[i], 6'd0, 1'b0);
                    ids.delete(i); dsts.delete(i); lives.delete(i);
                end else begin
                    i++;
                end
            end
        endfunction

        function void note_request(rrpq_pkg::t_req q);
            int unsigned cap;
            logic ok, dup;
            logic [31:0] rid, rdst;
            ok = 0; rid = 0; rdst = 0; dup = 0;
            if (q.req_type <= rrpq_pkg::REQ_SIZE && q.req_type != rrpq_pkg::REQ_FIND)
                sweep(1'b0, '0, rrpq_pkg::CAUSE_EXPIRED);
            case (q.req_type)
                rrpq_pkg::REQ_TICK: begin
                    foreach (lives[i]) if (!lives[i][16]) lives[i] = lives[i] - 17'd1;
                end
                rrpq_pkg::REQ_ENQ: begin
                    cap = max_len < 1 ? 1 : (max_len > DEPTH ? DEPTH : max_len);
                    foreach (ids[i])
                        if (ids[i] == q.packet_id && dsts[i] == q.dest_addr) dup = 1;
                    if (!dup) begin
                        while (ids.size() >= cap && ids.size() > 0) begin
                            put_word(1'b1, rrpq_pkg::CAUSE_EVICTED, 1'b0, ids[0], dsts[0],
                                     6'd0, 1'b0);
                            void'(ids.pop_front()); void'(dsts.pop_front());
                            void'(lives.pop_front());
                        end
                        ids.insert(ids.size(), q.packet_id);
                        dsts.insert(dsts.size(), q.dest_addr);
                        lives.insert(lives.size(), {1'b0, timeout});
                        ok = 1;
                    end
                end
                rrpq_pkg::REQ_DEQ: begin
                    for (int i = 0; i < ids.size(); i++)
                        if (dsts[i] == q.dest_addr) begin
                            ok = 1; rid = ids[i]; rdst = dsts[i];
                            ids.delete(i); dsts.delete(i); lives.delete(i);
                            break;
                        end
                end
                rrpq_pkg::REQ_DROP: sweep(1'b1, q.dest_addr, rrpq_pkg::CAUSE_BY_DEST);
                rrpq_pkg::REQ_FIND: foreach (dsts[i]) if (dsts[i] == q.dest_addr) ok = 1;
                default: ;
            endcase
            put_word(1'b0, rrpq_pkg::CAUSE_EXPIRED, ok, rid, rdst, 6'(ids.size()), 1'b1);
        endfunction

        function void check_word(rrpq_pkg::t_result a);
            rrpq_pkg::t_result e;
            words++;
            if (pending.size() == 0) begin
                $error("unexpected result word %p", a);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.is_drop !== e.is_drop) begin
                $error("is_drop exp %0h got %0h", e.is_drop, a.is_drop); errors++; end
            if (a.drop_cause !== e.drop_cause) begin
                $error("drop_cause exp %0h got %0h", e.drop_cause, a.drop_cause); errors++; end
            if (a.success !== e.success) begin
                $error("success exp %0h got %0h", e.success, a.success); errors++; end
            if (a.out_packet_id !== e.out_packet_id) begin
                $error("out_packet_id exp %0h got %0h", e.out_packet_id, a.out_packet_id);
                errors++;
            end
            if (a.out_dest !== e.out_dest) begin
                $error("out_dest exp %0h got %0h", e.out_dest, a.out_dest); errors++; end
            if (a.entry_count !== e.entry_count) begin
                $error("entry_count exp %0d got %0d", e.entry_count, a.entry_count); errors++; end
            if (a.last !== e.last) begin
                $error("last exp %0h got %0h", e.last, a.last); errors++; end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_start = 0;
    rrpq_pkg::t_req    i_req = '0;
    logic        o_busy;
    logic        o_valid;
    rrpq_pkg::t_result o_result;
    logic        i_cfg_we = 0;
    logic [rrpq_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [rrpq_pkg::TOUT_W-1:0]    i_cfg_data = '0;

    queue_scoreboard sb = new();
    int idle_pct = 0;
    int quiet_cycles = 0;
    int req_count = 0;
    logic [31:0] dest_pool[8];
    logic [31:0] id_pool[8];

    route_request_packet_queue dut (.*);

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    always @(posedge i_clk) begin
        if (o_valid) sb.check_word(o_result);
        if ((i_start && !o_busy) || o_valid || !i_rst_n) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG) begin
            $display("watchdog expired after %0d requests", req_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_req(logic [2:0] kind, logic [31:0] id, logic [31:0] dst);
        rrpq_pkg::t_req q;
        while ($urandom_range(99) < idle_pct) @(negedge i_clk);
        q.req_type = kind; q.packet_id = id; q.dest_addr = dst;
        i_req <= q;
        i_start <= 1;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        sb.note_request(q);
        req_count++;
        @(negedge i_clk);
        i_start <= 0;
        @(negedge i_clk);
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
    endtask

    task automatic write_cfg(logic [rrpq_pkg::CFG_IDX_W-1:0] idx,
                             logic [rrpq_pkg::TOUT_W-1:0] v);
        drain();
        i_cfg_we <= 1; i_cfg_idx <= idx; i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 0;
        if (idx == rrpq_pkg::CFG_MAX_LENGTH) sb.max_len = v[5:0];
        else sb.timeout = v;
    endtask

    task automatic random_req();
        int sel;
        logic [31:0] d, id;
        sel = $urandom_range(99);
        d  = $urandom_range(9) == 0 ? $urandom() : dest_pool[$urandom_range(7)];
        id = $urandom_range(4) == 0 ? $urandom() : id_pool[$urandom_range(7)];
        if (sel < 40) send_req(rrpq_pkg::REQ_ENQ, id, d);
        else if (sel < 55) send_req(rrpq_pkg::REQ_TICK, $urandom(), $urandom());
        else if (sel < 67) send_req(rrpq_pkg::REQ_DEQ, $urandom(), d);
        else if (sel < 75) send_req(rrpq_pkg::REQ_DROP, $urandom(), d);
        else if (sel < 86) send_req(rrpq_pkg::REQ_FIND, $urandom(), d);
        else if (sel < 96) send_req(rrpq_pkg::REQ_SIZE, $urandom(), $urandom());
        else send_req($urandom_range(1) ? REQ_BAD6 : REQ_BAD7, $urandom(), d);
    endtask

    initial begin
        int lens[5] = '{32, 1, 4, 0, 63};
        int touts[5] = '{30, 0, 3, 65535, 2};
        int idles[4] = '{0, 82, 0, 28};
        foreach (dest_pool[i]) begin
            dest_pool[i] = $urandom(); id_pool[i] = $urandom();
        end
        dest_pool[0] = '1; dest_pool[1] = '0; id_pool[0] = '1; id_pool[1] = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // directed: extremes, duplicate, eviction, expiry, unknown requests
        send_req(rrpq_pkg::REQ_SIZE, '0, '0);
        send_req(rrpq_pkg::REQ_ENQ, '1, '1);
        send_req(rrpq_pkg::REQ_ENQ, '1, '1);
        send_req(rrpq_pkg::REQ_ENQ, '0, '0);
        send_req(rrpq_pkg::REQ_ENQ, 32'h1234_5678, '1);
        send_req(rrpq_pkg::REQ_FIND, '0, '1);
        send_req(rrpq_pkg::REQ_FIND, '0, 32'h5555_aaaa);
        send_req(rrpq_pkg::REQ_DEQ, '0, '1);
        send_req(rrpq_pkg::REQ_DEQ, '0, 32'h5555_aaaa);
        send_req(rrpq_pkg::REQ_DROP, '0, '0);
        send_req(rrpq_pkg::REQ_DROP, '0, '1);
        send_req(REQ_BAD6, '1, '1);
        send_req(REQ_BAD7, '0, '0);
        write_cfg(rrpq_pkg::CFG_ENTRY_TIMEOUT, 16'd1);
        write_cfg(rrpq_pkg::CFG_MAX_LENGTH, 16'd2);
        send_req(rrpq_pkg::REQ_ENQ, 32'd1, 32'd10);
        send_req(rrpq_pkg::REQ_ENQ, 32'd2, 32'd10);
        send_req(rrpq_pkg::REQ_ENQ, 32'd3, 32'd11);
        send_req(rrpq_pkg::REQ_TICK, '0, '0);
        send_req(rrpq_pkg::REQ_TICK, '0, '0);
        send_req(rrpq_pkg::REQ_FIND, '0, 32'd11);
        send_req(rrpq_pkg::REQ_TICK, '0, '0);
        send_req(rrpq_pkg::REQ_SIZE, '0, '0);

        for (int ph = 0; ph < 5; ph++) begin
            write_cfg(rrpq_pkg::CFG_MAX_LENGTH, 16'(lens[ph]));
            write_cfg(rrpq_pkg::CFG_ENTRY_TIMEOUT, 16'(touts[ph]));
            for (int k = 0; k < 4; k++) begin
                idle_pct = idles[k];
                repeat (20) random_req();
            end
        end
        idle_pct = 0;
        drain();
        $display("ran %0d requests, %0d result words, over five length/timeout settings",
                 req_count, sb.words);
        if (sb.errors == 0) $display("Test completed successfully");
        else $display("Test completed with failures");
        $finish;
    end
endmodule

FILE: route_request_packet_queue.f
design/rrpq_pkg.sv
design/rrpq_ctrl.sv
design/rrpq_dp.sv
design/route_request_packet_queue.sv
test/tb_route_request_packet_queue.sv
